/* rtl/ssam_pkg.sv */
package ssam_pkg;

   // Command codes carried in the command field of an input item.
   typedef enum logic [2:0] {
      CMD_LOAD_HEADER = 3'd0,
      CMD_LOAD_BYTE   = 3'd1,
      CMD_TICK        = 3'd2,
      CMD_QUERY       = 3'd3,
      CMD_READ_BYTE   = 3'd4
   } cmd_type;

   // Largest header offset that is accepted; anything above flags an error.
   localparam int unsigned HEADER_OFFSET_MAX = 32;
   // Number of window bits in one map byte.
   localparam int unsigned BYTE_BITS = 8;

   typedef logic [BYTE_BITS-1:0] map_byte_type;

   // One input item.
   typedef struct packed {
      cmd_type      command;
      logic [31:0]  start_word;
      logic [5:0]   bit_offset;
      logic [4:0]   byte_index;
      map_byte_type map_byte;
      logic [31:0]  segment_id;
   } req_type;

   // One result item.
   typedef struct packed {
      logic         keep;
      map_byte_type byte_out;
      logic [31:0]  start_out;
      logic         error;
   } rsp_type;

   // Control from the command decode to the availability bit store.
   typedef struct packed {
      logic         tick;
      logic         load;
      logic [4:0]   byte_index;
      map_byte_type map_byte;
      map_byte_type write_mask;
   } map_ctrl_type;

endpackage

/* rtl/ssam_map.sv */
module ssam_map
   import ssam_pkg::*;
#(
   parameter int SEGMENT_COUNT = 256
) (
   input  logic                             clock,
   input  logic                             reset,
   input  map_ctrl_type                     ctrl,
   input  logic [$clog2(SEGMENT_COUNT)-1:0] query_index,
   output map_byte_type                     read_byte,
   output logic                             query_bit
);

   localparam int IDX_W = $clog2(SEGMENT_COUNT);
   // A byte position {byte_index, j} needs eight bits; wide windows need more.
   localparam int POS_W = (IDX_W > 8) ? IDX_W : 8;

   logic [SEGMENT_COUNT-1:0] bits_ff;
   logic [SEGMENT_COUNT-1:0] bits_in;

   // Byte load, byte read and the one-place shift of a tick. Positions beyond
   // the window are not stored: loads to them drop and reads give zero.
   always_comb begin
      logic [POS_W-1:0] pos;
      logic             hit;
      bits_in   = bits_ff;
      read_byte = '0;
      for (int j = 0; j < BYTE_BITS; j++) begin
         pos = POS_W'({ctrl.byte_index, 3'(j)});
         hit = ({1'b0, pos} < (POS_W+1)'(SEGMENT_COUNT));
         read_byte[j] = hit & bits_ff[pos[IDX_W-1:0]];
         if (ctrl.load && hit && ctrl.write_mask[j]) begin
            bits_in[pos[IDX_W-1:0]] = ctrl.map_byte[j];
         end
      end
      if (ctrl.tick) begin
         bits_in = {1'b0, bits_ff[SEGMENT_COUNT-1:1]};
      end
   end

   assign query_bit = bits_ff[query_index];

   always_ff @(posedge clock) begin
      if (reset) begin
         bits_ff <= '0;
      end else begin
         bits_ff <= bits_in;
      end
   end

endmodule

/* rtl/sliding_segment_availability_map_unit.sv */
// Sliding segment-availability map. Each item (load_header, load_byte, tick,
// query, read_byte) is registered on the edge that accepts it, decoded and
// applied to the window in the following cycle, and its one result is on
// rsp_data with rsp_valid high for exactly one cycle after that. A new item
// can be taken every cycle that busy is low; busy is high only during reset
// and is cleared by a clock edge with reset low. Results cannot be held off,
// so the receiver must take rsp_data in the cycle rsp_valid is high. The
// window is a shift register of SEGMENT_COUNT flip-flops, so a tick moves all
// bits at once and every command is applied to the window in a single update.
module sliding_segment_availability_map_unit
   import ssam_pkg::*;
#(
   parameter int SEGMENT_COUNT = 256
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int IDX_W = $clog2(SEGMENT_COUNT);

   logic         busy_ff;
   logic         req_valid_ff;
   req_type      req_ff;
   logic [31:0]  start_ff;
   logic [31:0]  start_in;
   logic [5:0]   offset_ff;
   logic [5:0]   offset_in;
   logic         rsp_valid_ff;
   rsp_type      rsp_ff;
   rsp_type      rsp_in;
   logic [31:0]  seg_dist;
   map_ctrl_type map_ctrl;
   map_byte_type read_byte;
   logic         query_bit;

   assign busy = busy_ff;

   // Input register: an item is taken whenever start is high and not busy.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b1;
         req_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= 1'b0;
         req_valid_ff <= start & ~busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_data;
   end

   // Distance of the queried segment from the window start, two's complement.
   assign seg_dist = req_ff.segment_id - start_ff;

   // Control for the bit store. Byte zero keeps its bits below the offset.
   always_comb begin
      map_ctrl            = '0;
      map_ctrl.tick       = req_valid_ff && (req_ff.command == CMD_TICK);
      map_ctrl.load       = req_valid_ff && (req_ff.command == CMD_LOAD_BYTE);
      map_ctrl.byte_index = req_ff.byte_index;
      map_ctrl.map_byte   = req_ff.map_byte;
      for (int j = 0; j < BYTE_BITS; j++) begin
         map_ctrl.write_mask[j] = (req_ff.byte_index != '0) || (6'(j) >= offset_ff);
      end
   end

   ssam_map #(
      .SEGMENT_COUNT (SEGMENT_COUNT)
   ) u_map (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (map_ctrl),
      .query_index (seg_dist[IDX_W-1:0]),
      .read_byte   (read_byte),
      .query_bit   (query_bit)
   );

   // Command decode: start and offset updates and the result fields.
   always_comb begin
      start_in  = start_ff;
      offset_in = offset_ff;
      rsp_in    = '0;
      if (req_valid_ff) begin
         case (req_ff.command)
            CMD_LOAD_HEADER: begin
               if (req_ff.bit_offset > 6'(HEADER_OFFSET_MAX)) begin
                  rsp_in.error = 1'b1;
               end else begin
                  start_in  = req_ff.start_word + 32'(req_ff.bit_offset);
                  offset_in = req_ff.bit_offset;
               end
            end
            CMD_TICK: begin
               start_in = start_ff + 32'd1;
            end
            CMD_QUERY: begin
               // Dropped before the start, or inside the window with a clear bit.
               // The last window position and beyond always count as kept.
               if (seg_dist[31]) begin
                  rsp_in.keep = 1'b0;
               end else if ((seg_dist < 32'(SEGMENT_COUNT - 1)) && !query_bit) begin
                  rsp_in.keep = 1'b0;
               end else begin
                  rsp_in.keep = 1'b1;
               end
            end
            CMD_READ_BYTE: begin
               rsp_in.byte_out = read_byte;
            end
            default: begin
            end
         endcase
      end
      rsp_in.start_out = start_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff     <= '0;
         offset_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         start_ff     <= start_in;
         offset_ff    <= offset_in;
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* rtl/ssam_checker.sv */
module ssam_checker
   import ssam_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_data,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   logic        accept;
   logic [31:0] seg_d1_ff;
   logic [31:0] seg_d2_ff;
   logic [31:0] query_dist;

   assign accept = start & ~busy;

   // Segment id of the item whose result is on the ports now.
   always_ff @(posedge clock) begin
      seg_d1_ff <= req_data.segment_id;
      seg_d2_ff <= seg_d1_ff;
   end

   assign query_dist = seg_d2_ff - rsp_data.start_out;

   // Every accepted item yields a result on rsp_valid.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##2 rsp_valid)
      else $error("accepted item produced no result");

   // No result appears without an accepted item behind it.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 2))
      else $error("result without an accepted item");

   // An error is only reported for a header whose offset is out of range.
   a_error_cause: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.error) |->
         (($past(req_data.command, 2) == CMD_LOAD_HEADER) &&
          ($past(req_data.bit_offset, 2) > 6'(HEADER_OFFSET_MAX))))
      else $error("error flag on a valid command");

   // A query for a segment before the window start is always dropped.
   a_query_before_start: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && ($past(req_data.command, 2) == CMD_QUERY) && query_dist[31])
         |-> !rsp_data.keep)
      else $error("segment before the window start reported as kept");

   // Only a query may report a kept segment.
   a_keep_only_query: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && ($past(req_data.command, 2) != CMD_QUERY)) |-> !rsp_data.keep)
      else $error("keep set on a non-query result");

endmodule

bind sliding_segment_availability_map_unit ssam_checker u_ssam_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

/* tb/sliding_segment_availability_map_unit_test.sv */
`timescale 1ns / 100ps

module sliding_segment_availability_map_unit_test;
   import ssam_pkg::*;

   localparam int SEGMENT_COUNT = 256;
   localparam int RANDOM_ITEMS  = 1500;
   localparam int QUIET_TAIL    = 200;
   localparam int STALL_LIMIT   = 2000;
   localparam int REPORT_LIMIT  = 10;

   // Tracks the window the block should hold and the results it owes.
   class availability_map_scoreboard;
      logic [31:0]              window_start;
      logic [SEGMENT_COUNT-1:0] avail;
      logic [5:0]               pending_offset;
      rsp_type                  expected_results[$];
      int                       mismatches;
      int                       checked;
      int                       cmd_count[5];
      int                       rejected_headers;
      int                       kept_queries;

      function new();
         window_start     = '0;
         avail            = '0;
         pending_offset   = '0;
         mismatches       = 0;
         checked          = 0;
         rejected_headers = 0;
         kept_queries     = 0;
         foreach (cmd_count[c]) cmd_count[c] = 0;
      endfunction

      // Applies one accepted item to the window and queues the result it causes.
      function void note_command(req_type item);
         rsp_type     want;
         logic [31:0] seg_dist;
         int          pos;
         want = '0;
         if (int'(item.command) < 5) cmd_count[int'(item.command)]++;
         case (item.command)
            CMD_LOAD_HEADER: begin
               if (item.bit_offset > HEADER_OFFSET_MAX) begin
                  want.error = 1'b1;
                  rejected_headers++;
               end else begin
                  window_start   = item.start_word + 32'(item.bit_offset);
                  pending_offset = item.bit_offset;
               end
            end
            CMD_LOAD_BYTE: begin
               // Low bits of byte zero below the header offset are left alone.
               for (int j = 0; j < BYTE_BITS; j++) begin
                  pos = int'(item.byte_index) * BYTE_BITS + j;
                  if (!(item.byte_index == 0 && j < pending_offset) && pos < SEGMENT_COUNT)
                     avail[pos] = item.map_byte[j];
               end
            end
            CMD_TICK: begin
               window_start = window_start + 32'd1;
               avail        = avail >> 1;
            end
            CMD_QUERY: begin
               // Ids before the start are dropped; ids at or past the last
               // window position are kept regardless of the bits.
               seg_dist = item.segment_id - window_start;
               if (seg_dist[31])
                  want.keep = 1'b0;
               else if (seg_dist < SEGMENT_COUNT - 1)
                  want.keep = avail[seg_dist];
               else
                  want.keep = 1'b1;
               if (want.keep) kept_queries++;
            end
            CMD_READ_BYTE: begin
               for (int j = 0; j < BYTE_BITS; j++) begin
                  pos = int'(item.byte_index) * BYTE_BITS + j;
                  if (pos < SEGMENT_COUNT) want.byte_out[j] = avail[pos];
               end
            end
            default: ;
         endcase
         want.start_out = window_start;
         expected_results.push_back(want);
      endfunction

      function void report(string what, rsp_type want, rsp_type got);
         mismatches++;
         if (mismatches <= REPORT_LIMIT) begin
            $display("mismatch (%s) at %0t: expected keep=%b byte=%h start=%h err=%b",
                     what, $time, want.keep, want.byte_out, want.start_out, want.error);
            $display("   actual keep=%b byte=%h start=%h err=%b",
                     got.keep, got.byte_out, got.start_out, got.error);
         end
      endfunction

      // Compares one result with the oldest outstanding expectation.
      function void check_result(rsp_type got);
         rsp_type want;
         if (expected_results.size() == 0) begin
            report("no item outstanding", '0, got);
            return;
         end
         want = expected_results.pop_front();
         checked++;
         if (got.keep !== want.keep || got.byte_out !== want.byte_out ||
             got.start_out !== want.start_out || got.error !== want.error)
            report("field", want, got);
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;
   int      stall_cycles;

   availability_map_scoreboard sb = new();

   sliding_segment_availability_map_unit #(.SEGMENT_COUNT(SEGMENT_COUNT)) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Note accepted items and check results on the same edges the block uses.
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) sb.note_command(req_data);
         if (rsp_valid) sb.check_result(rsp_data);
      end
   end

   // Give up when nothing moves on either side for too long.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Presents one item and holds it until the block takes it.
   task automatic send_item(cmd_type cmd, logic [31:0] word, logic [5:0] offs,
                            logic [4:0] k, logic [7:0] mbyte, logic [31:0] seg);
      req_type item;
      item.command    = cmd;
      item.start_word = word;
      item.bit_offset = offs;
      item.byte_index = k;
      item.map_byte   = mbyte;
      item.segment_id = seg;
      start    <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic idle_for(int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Holds off until every outstanding result has come back.
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (sb.expected_results.size() != 0) @(posedge clock);
   endtask

   initial begin
      logic [31:0] hint;
      logic [31:0] word;
      logic [31:0] seg;
      logic [5:0]  offs;
      int          pick;
      cmd_type     cmd;

      stall_cycles = 0;
      reset        = 1'b1;
      start        = 1'b0;
      req_data     = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed part: reset contents, header offsets at and past the limit,
      // protected low bits of byte zero, start wrap-around and query edges.
      send_item(CMD_READ_BYTE,   32'h0,        6'd0,  5'd0,  8'h00, 32'h0);
      send_item(CMD_QUERY,       32'h0,        6'd0,  5'd0,  8'h00, 32'h0);
      send_item(CMD_LOAD_HEADER, 32'hFFFFFFF0, 6'd32, 5'd0,  8'h00, 32'h0);
      send_item(CMD_LOAD_BYTE,   32'h0,        6'd0,  5'd0,  8'hFF, 32'h0);
      send_item(CMD_LOAD_HEADER, 32'h1234,     6'd33, 5'd0,  8'h00, 32'h0);
      send_item(CMD_LOAD_HEADER, 32'h0,        6'd63, 5'd0,  8'h00, 32'h0);
      send_item(CMD_LOAD_HEADER, 32'd100,      6'd5,  5'd0,  8'h00, 32'h0);
      send_item(CMD_LOAD_BYTE,   32'h0,        6'd0,  5'd0,  8'hFF, 32'h0);
      send_item(CMD_LOAD_BYTE,   32'h0,        6'd0,  5'd31, 8'hA5, 32'h0);
      send_item(CMD_LOAD_BYTE,   32'h0,        6'd0,  5'd15, 8'hFF, 32'h0);
      send_item(CMD_LOAD_HEADER, 32'hFFFFFFFF, 6'd0,  5'd0,  8'h00, 32'h0);
      send_item(CMD_LOAD_BYTE,   32'h0,        6'd0,  5'd1,  8'h81, 32'h0);
      send_item(CMD_READ_BYTE,   32'h0,        6'd0,  5'd0,  8'h00, 32'h0);
      send_item(CMD_READ_BYTE,   32'h0,        6'd0,  5'd31, 8'h00, 32'h0);
      send_item(CMD_READ_BYTE,   32'h0,        6'd0,  5'd15, 8'h00, 32'h0);
      send_item(CMD_TICK,        32'h0,        6'd0,  5'd0,  8'h00, 32'h0);
      send_item(CMD_READ_BYTE,   32'h0,        6'd0,  5'd0,  8'h00, 32'h0);
      drain();
      hint = sb.window_start;
      send_item(CMD_QUERY, 32'h0, 6'd0, 5'd0, 8'h00, hint);
      send_item(CMD_QUERY, 32'h0, 6'd0, 5'd0, 8'h00, hint - 32'd1);
      send_item(CMD_QUERY, 32'h0, 6'd0, 5'd0, 8'h00, hint + 32'd254);
      send_item(CMD_QUERY, 32'h0, 6'd0, 5'd0, 8'h00, hint + 32'd255);
      send_item(CMD_QUERY, 32'h0, 6'd0, 5'd0, 8'h00, hint + 32'd1000);
      send_item(CMD_QUERY, 32'h0, 6'd0, 5'd0, 8'h00, hint + 32'h7FFFFFFF);
      send_item(CMD_QUERY, 32'h0, 6'd0, 5'd0, 8'h00, hint + 32'h80000000);
      send_item(CMD_LOAD_BYTE, 32'h0, 6'd0, 5'd0, 8'h3C, 32'h0);
      send_item(CMD_TICK,      32'h0, 6'd0, 5'd0, 8'h00, 32'h0);
      drain();

      // Random part: queries aimed mostly around the current window, headers
      // mostly near the current start, with occasional bad offsets.
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         hint = sb.window_start;
         pick = $urandom_range(0, 99);
         if (pick < 15)      cmd = CMD_LOAD_HEADER;
         else if (pick < 37) cmd = CMD_LOAD_BYTE;
         else if (pick < 50) cmd = CMD_TICK;
         else if (pick < 85) cmd = CMD_QUERY;
         else                cmd = CMD_READ_BYTE;

         offs = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(33, 63))
                                            : 6'($urandom_range(0, 32));
         word = $urandom;
         if ($urandom_range(0, 2) != 0) word = hint - 32'(offs) + $urandom_range(0, 40);

         case ($urandom_range(0, 4))
            0:       seg = hint + $urandom_range(0, 300);
            1:       seg = hint - $urandom_range(1, 20);
            2:       seg = hint + $urandom_range(250, 260);
            3:       seg = hint + $urandom_range(0, 63);
            default: seg = $urandom;
         endcase

         send_item(cmd, word, offs, 5'($urandom_range(0, 31)), 8'($urandom), seg);

         if (i == RANDOM_ITEMS / 3 || i == 2 * RANDOM_ITEMS / 3)
            drain();
         else if (i < RANDOM_ITEMS - QUIET_TAIL && $urandom_range(0, 5) == 0)
            idle_for($urandom_range(1, 8));
      end

      // Let the last results come back, then idle before the report.
      drain();
      repeat (10) @(posedge clock);

      $display("Ran %0d headers (%0d rejected), %0d byte loads, %0d ticks,",
               sb.cmd_count[CMD_LOAD_HEADER], sb.rejected_headers,
               sb.cmd_count[CMD_LOAD_BYTE], sb.cmd_count[CMD_TICK]);
      $display("%0d queries (%0d kept), %0d byte reads; %0d results checked, %0d mismatches.",
               sb.cmd_count[CMD_QUERY], sb.kept_queries, sb.cmd_count[CMD_READ_BYTE],
               sb.checked, sb.mismatches);
      if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/ssam_pkg.sv
rtl/ssam_map.sv
rtl/sliding_segment_availability_map_unit.sv
rtl/ssam_checker.sv
tb/sliding_segment_availability_map_unit_test.sv
